@@ sv/bsk_pkg.sv @@
// ----------------------------------------------------------------------------
// bsk_pkg
// Shared types and constants of the bounded smallest-k keeper.
// ----------------------------------------------------------------------------
package bsk_pkg;

   localparam int DATA_W          = 32;
   localparam int CNT_W           = 6;
   localparam int CMD_W           = 2;
   localparam int MAX_ENTRIES_DEF = 32;
   localparam int KEY_WIDTH_DEF   = 32;
   localparam int CAP_RESET       = 32;

   localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READOUT = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NOP     = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]         command;
      logic signed [DATA_W-1:0] sort_key;
      logic [DATA_W-1:0]        coord_x;
      logic [DATA_W-1:0]        coord_y;
      logic signed [DATA_W-1:0] entry_id;
   } op_type;

endpackage

@@ sv/bsk_req_if.sv @@
// ----------------------------------------------------------------------------
// bsk_req_if
// Request channel: one command beat with key and payload.
// ----------------------------------------------------------------------------
interface bsk_req_if
   import bsk_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic [CMD_W-1:0]         command;
   logic signed [DATA_W-1:0] sort_key;
   logic [DATA_W-1:0]        coord_x;
   logic [DATA_W-1:0]        coord_y;
   logic signed [DATA_W-1:0] entry_id;

   modport source (output valid, command, sort_key, coord_x, coord_y, entry_id,
                   input ready);
   modport sink   (input valid, command, sort_key, coord_x, coord_y, entry_id,
                   output ready);
endinterface

@@ sv/bsk_rsp_if.sv @@
// ----------------------------------------------------------------------------
// bsk_rsp_if
// Response channel: one result beat.
// ----------------------------------------------------------------------------
interface bsk_rsp_if
   import bsk_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic                     accepted;
   logic [CNT_W-1:0]         count;
   logic signed [DATA_W-1:0] out_key;
   logic [DATA_W-1:0]        out_x;
   logic [DATA_W-1:0]        out_y;
   logic signed [DATA_W-1:0] out_id;
   logic                     empty_res;
   logic                     last;

   modport source (output valid, accepted, count, out_key, out_x, out_y, out_id,
                   empty_res, last, input ready);
   modport sink   (input valid, accepted, count, out_key, out_x, out_y, out_id,
                   empty_res, last, output ready);
endinterface

@@ sv/bsk_front.sv @@
// ----------------------------------------------------------------------------
// bsk_front
// Accepts request beats, maps unknown commands to no-op, queues two deep.
// ----------------------------------------------------------------------------
module bsk_front
   import bsk_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   bsk_req_if.sink req,
   output op_type q_op,
   output logic   q_valid,
   input  logic   q_pop
);

   op_type     slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push;
   logic       pop;
   op_type     cls_op;

   assign req.ready = (fill_ff != 2'd2);
   assign push      = req.valid && req.ready;
   assign q_valid   = (fill_ff != 2'd0);
   assign pop       = q_pop && q_valid;
   assign q_op      = slot_ff[rd_ptr_ff];

   always_comb begin
      cls_op.sort_key = req.sort_key;
      cls_op.coord_x  = req.coord_x;
      cls_op.coord_y  = req.coord_y;
      cls_op.entry_id = req.entry_id;
      case (req.command)
         CMD_CLEAR:   cls_op.command = CMD_CLEAR;
         CMD_INSERT:  cls_op.command = CMD_INSERT;
         CMD_READOUT: cls_op.command = CMD_READOUT;
         default:     cls_op.command = CMD_NOP;
      endcase
   end

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= cls_op;
      end
   end

endmodule

@@ sv/bsk_cell_row.sv @@
// ----------------------------------------------------------------------------
// bsk_cell_row
// Compare-and-shift cell row holding the sorted entries, plus readout
// sequencer and result register.
// ----------------------------------------------------------------------------
module bsk_cell_row
   import bsk_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
   parameter int KEY_WIDTH   = KEY_WIDTH_DEF
)(
   input  logic             clock,
   input  logic             reset,
   input  op_type           q_op,
   input  logic             q_valid,
   output logic             q_pop,
   input  logic             csr_write_enable,
   input  logic [CNT_W-1:0] csr_write_data,
   bsk_rsp_if.source        rsp
);

   localparam int IDX_W    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int HC_W     = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W    = (KEY_WIDTH < DATA_W) ? KEY_WIDTH : DATA_W;
   localparam int CAP_INIT = (CAP_RESET > MAX_ENTRIES) ? MAX_ENTRIES : CAP_RESET;

   logic [DATA_W-1:0] key_ff [MAX_ENTRIES];
   logic [DATA_W-1:0] x_ff   [MAX_ENTRIES];
   logic [DATA_W-1:0] y_ff   [MAX_ENTRIES];
   logic [DATA_W-1:0] id_ff  [MAX_ENTRIES];
   logic [DATA_W-1:0] key_in [MAX_ENTRIES];
   logic [DATA_W-1:0] x_in   [MAX_ENTRIES];
   logic [DATA_W-1:0] y_in   [MAX_ENTRIES];
   logic [DATA_W-1:0] id_in  [MAX_ENTRIES];

   logic [MAX_ENTRIES-1:0] le;
   logic [MAX_ENTRIES-1:0] vld;
   logic [HC_W-1:0]        held_ff, held_in;
   logic [HC_W-1:0]        cap_ff, cap_in;
   logic                   busy_ff, busy_in;
   logic [IDX_W-1:0]       rd_idx_ff, rd_idx_in;

   logic              out_valid_ff, out_valid_in;
   logic              out_acc_ff, out_acc_in;
   logic [CNT_W-1:0]  out_cnt_ff, out_cnt_in;
   logic [DATA_W-1:0] out_key_ff, out_key_in;
   logic [DATA_W-1:0] out_x_ff, out_x_in;
   logic [DATA_W-1:0] out_y_ff, out_y_in;
   logic [DATA_W-1:0] out_id_ff, out_id_in;
   logic              out_empty_ff, out_empty_in;
   logic              out_last_ff, out_last_in;

   logic out_free;
   logic full;
   logic refuse;
   logic do_insert;
   logic rd_last;

   assign out_free = !out_valid_ff || rsp.ready;
   assign q_pop    = q_valid && !busy_ff && out_free;
   assign full     = (held_ff == cap_ff);
   assign refuse   = full && (&(le | ~vld));
   assign do_insert = q_pop && (q_op.command == CMD_INSERT) && !refuse;
   assign rd_last  = ((HC_W'(rd_idx_ff) + HC_W'(1)) == held_ff);

   always_comb begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         vld[i] = (HC_W'(i) < held_ff);
         le[i]  = vld[i] && ($signed(key_ff[i][CMP_W-1:0]) <=
                             $signed(q_op.sort_key[CMP_W-1:0]));
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         key_in[i] = key_ff[i];
         x_in[i]   = x_ff[i];
         y_in[i]   = y_ff[i];
         id_in[i]  = id_ff[i];
         if (!le[i]) begin
            if (i == 0 || le[(i == 0) ? 0 : i-1]) begin
               key_in[i] = q_op.sort_key;
               x_in[i]   = q_op.coord_x;
               y_in[i]   = q_op.coord_y;
               id_in[i]  = q_op.entry_id;
            end else begin
               key_in[i] = key_ff[(i == 0) ? 0 : i-1];
               x_in[i]   = x_ff[(i == 0) ? 0 : i-1];
               y_in[i]   = y_ff[(i == 0) ? 0 : i-1];
               id_in[i]  = id_ff[(i == 0) ? 0 : i-1];
            end
         end
      end
   end

   always_comb begin
      held_in      = held_ff;
      cap_in       = cap_ff;
      busy_in      = busy_ff;
      rd_idx_in    = rd_idx_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      out_acc_in   = out_acc_ff;
      out_cnt_in   = out_cnt_ff;
      out_key_in   = out_key_ff;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_id_in    = out_id_ff;
      out_empty_in = out_empty_ff;
      out_last_in  = out_last_ff;

      if (busy_ff && out_free) begin
         out_valid_in = 1'b1;
         out_acc_in   = 1'b0;
         out_cnt_in   = CNT_W'(held_ff);
         out_key_in   = key_ff[rd_idx_ff];
         out_x_in     = x_ff[rd_idx_ff];
         out_y_in     = y_ff[rd_idx_ff];
         out_id_in    = id_ff[rd_idx_ff];
         out_empty_in = 1'b0;
         out_last_in  = rd_last;
         rd_idx_in    = rd_idx_ff + IDX_W'(1);
         if (rd_last) begin
            busy_in = 1'b0;
         end
      end else if (q_pop) begin
         out_valid_in = 1'b1;
         out_acc_in   = 1'b0;
         out_key_in   = '0;
         out_x_in     = '0;
         out_y_in     = '0;
         out_id_in    = '0;
         out_empty_in = 1'b0;
         out_last_in  = 1'b1;
         case (q_op.command)
            CMD_CLEAR: begin
               held_in = '0;
            end
            CMD_INSERT: begin
               if (!refuse) begin
                  out_acc_in = 1'b1;
                  if (!full) begin
                     held_in = held_ff + HC_W'(1);
                  end
               end
            end
            CMD_READOUT: begin
               if (held_ff == '0) begin
                  out_empty_in = 1'b1;
               end else begin
                  out_valid_in = 1'b0;
                  busy_in      = 1'b1;
                  rd_idx_in    = '0;
               end
            end
            default: begin
            end
         endcase
         out_cnt_in = CNT_W'(held_in);
      end

      if (csr_write_enable) begin
         held_in = '0;
         cap_in  = (int'(csr_write_data) > MAX_ENTRIES) ? HC_W'(MAX_ENTRIES)
                                                        : HC_W'(csr_write_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= '0;
         cap_ff       <= HC_W'(CAP_INIT);
         busy_ff      <= 1'b0;
         rd_idx_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         held_ff      <= held_in;
         cap_ff       <= cap_in;
         busy_ff      <= busy_in;
         rd_idx_ff    <= rd_idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_acc_ff   <= out_acc_in;
      out_cnt_ff   <= out_cnt_in;
      out_key_ff   <= out_key_in;
      out_x_ff     <= out_x_in;
      out_y_ff     <= out_y_in;
      out_id_ff    <= out_id_in;
      out_empty_ff <= out_empty_in;
      out_last_ff  <= out_last_in;
      if (do_insert) begin
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            key_ff[i] <= key_in[i];
            x_ff[i]   <= x_in[i];
            y_ff[i]   <= y_in[i];
            id_ff[i]  <= id_in[i];
         end
      end
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.accepted  = out_acc_ff;
   assign rsp.count     = out_cnt_ff;
   assign rsp.out_key   = out_key_ff;
   assign rsp.out_x     = out_x_ff;
   assign rsp.out_y     = out_y_ff;
   assign rsp.out_id    = out_id_ff;
   assign rsp.empty_res = out_empty_ff;
   assign rsp.last      = out_last_ff;

endmodule

@@ sv/bounded_smallest_k_keeper_core.sv @@
// A request beat is written into a front queue slot, then into the result register
// once the cell row pops it. Clear and insert each take one pop of the cell row;
// a readout starts the sequencer, then emits one beat per held entry through the
// single result port, which can stall it; no new request is popped until it ends.
// Reset: synchronous; empties store and queue; capacity is min(32, MAX_ENTRIES).
// ----------------------------------------------------------------------------
// bounded_smallest_k_keeper_core
// Keeps the smallest-key entries up to a capacity, in stable sorted order.
// ----------------------------------------------------------------------------
module bounded_smallest_k_keeper_core
   import bsk_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
   parameter int KEY_WIDTH   = KEY_WIDTH_DEF
)(
   input  logic             clock,
   input  logic             reset,
   bsk_req_if.sink          req_bus,
   bsk_rsp_if.source        rsp_bus,
   input  logic             csr_write_enable,
   input  logic [CNT_W-1:0] csr_write_data
);

   op_type q_op;
   logic   q_valid;
   logic   q_pop;

   bsk_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req_bus),
      .q_op    (q_op),
      .q_valid (q_valid),
      .q_pop   (q_pop)
   );

   bsk_cell_row #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .KEY_WIDTH   (KEY_WIDTH)
   ) u_cell_row (
      .clock            (clock),
      .reset            (reset),
      .q_op             (q_op),
      .q_valid          (q_valid),
      .q_pop            (q_pop),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp              (rsp_bus)
   );

endmodule
